// ----- sv/sorted_range_search_unit_defines.svh -----
// Assertion macros shared by the sorted range search unit RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef SORTED_RANGE_SEARCH_UNIT_DEFINES_SVH
`define SORTED_RANGE_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/srs_pkg.sv -----
// Shared constants and controller/datapath types for the sorted range search unit.
// No dependencies.
`default_nettype none

package srs_pkg;

  localparam int DEPTH     = 1024;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int VAL_W     = 32;
  localparam int OUT_IDX_W = 11;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_START,
    CMD_LB_STEP,
    CMD_LB_CHECK,
    CMD_UB_STEP,
    CMD_OUT_LOAD
  } srs_op_t;

  typedef struct packed {
    srs_op_t op;
  } srs_cmd_t;

  typedef struct packed {
    logic empty;    // no words stored
    logic single;   // exactly one word stored
    logic lb_more;  // lower-bound search continues after this step
    logic ub_more;  // upper-bound search continues after this step
    logic hit;      // word read equals target
  } srs_sts_t;

endpackage

`default_nettype wire

// ----- sv/srs_if.sv -----
// Valid/ready channel interfaces for the sorted range search unit.
// Depends on srs_pkg for field widths.
`default_nettype none

interface srs_in_if import srs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [VAL_W-1:0] value;
  logic                    restart;

  modport source (output valid, output mode, output value, output restart, input ready);
  modport sink   (input valid, input mode, input value, input restart, output ready);
endinterface

interface srs_out_if import srs_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic signed [OUT_IDX_W-1:0] first_index;
  logic signed [OUT_IDX_W-1:0] last_index;

  modport source (output valid, output found, output first_index, output last_index,
                  input ready);
  modport sink   (input valid, input found, input first_index, input last_index,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/srs_ctrl.sv -----
// Sequencer for loads and the two binary searches of a query.
// Depends on srs_pkg and the assertion macros header.
`default_nettype none
`include "sorted_range_search_unit_defines.svh"

module srs_ctrl import srs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_mode,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire srs_sts_t sts,
  output srs_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LB_RUN,
    ST_LB_CHECK,
    ST_UB_RUN,
    ST_FINISH
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd.op = CMD_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = (in_mode == MODE_QUERY) ? CMD_START : CMD_LOAD;
        end
      end
      ST_LB_RUN:   cmd.op = CMD_LB_STEP;
      ST_LB_CHECK: cmd.op = CMD_LB_CHECK;
      ST_UB_RUN:   cmd.op = CMD_UB_STEP;
      ST_FINISH: begin
        if (out_free) begin
          cmd.op = CMD_OUT_LOAD;
        end
      end
      default:     cmd.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && in_mode == MODE_QUERY) begin
            priority if (sts.empty) begin
              state_r <= ST_FINISH;
            end else if (sts.single) begin
              state_r <= ST_LB_CHECK;
            end else begin
              state_r <= ST_LB_RUN;
            end
          end
        end
        ST_LB_RUN: begin
          if (!sts.lb_more) begin
            state_r <= ST_LB_CHECK;
          end
        end
        ST_LB_CHECK: begin
          state_r <= sts.hit ? ST_UB_RUN : ST_FINISH;
        end
        ST_UB_RUN: begin
          if (!sts.ub_more) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `SRS_ASSERT_NEXT(a_finish_waits, clk, rst_n, state_r == ST_FINISH && !out_free, state_r == ST_FINISH, "result dropped while output register busy")
  `SRS_ASSERT_NEXT(a_valid_source, clk, rst_n, !out_valid_r && state_r != ST_FINISH, !out_valid_r, "result shown outside finish")
  `SRS_ASSERT_NEXT(a_lb_to_check, clk, rst_n, state_r == ST_LB_RUN && !sts.lb_more, state_r == ST_LB_CHECK, "lower bound did not end in check")

endmodule

`default_nettype wire

// ----- sv/srs_datapath.sv -----
// Element store, search bounds, comparator and result register.
// Depends on srs_pkg and the assertion macros header.
`default_nettype none
`include "sorted_range_search_unit_defines.svh"

module srs_datapath import srs_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire srs_cmd_t                    cmd,
  input  wire logic signed [VAL_W-1:0]     in_value,
  input  wire logic                        in_restart,
  output srs_sts_t                         sts,
  output logic                             out_found,
  output logic signed [OUT_IDX_W-1:0]      out_first_index,
  output logic signed [OUT_IDX_W-1:0]      out_last_index
);

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rdata_r;
  logic signed [VAL_W-1:0] target_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        lo_r, hi_r, mid_r, first_r;
  logic                    found_r;
  logic                    out_found_r;
  logic signed [OUT_IDX_W-1:0] out_first_r, out_last_r;

  logic [CNT_W-1:0] wr_idx;
  logic             wr_ok;
  logic             less, greater;
  logic [CNT_W-1:0] lb_lo_n, lb_hi_n, ub_lo_n, ub_hi_n, mid_inc;
  logic [CNT_W-1:0] rd_addr;

  function automatic logic [CNT_W-1:0] midpoint(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CNT_W:1];
  endfunction

  assign wr_idx  = in_restart ? '0 : count_r;
  assign wr_ok   = in_restart || (count_r < CNT_W'(DEPTH));
  assign less    = rdata_r < target_r;
  assign greater = rdata_r > target_r;
  assign mid_inc = mid_r + 1'b1;
  assign lb_lo_n = less ? mid_inc : lo_r;
  assign lb_hi_n = less ? hi_r : mid_r;
  assign ub_lo_n = greater ? lo_r : mid_inc;
  assign ub_hi_n = greater ? mid_r : hi_r;

  assign sts.empty   = (count_r == '0);
  assign sts.single  = (count_r == CNT_W'(1));
  assign sts.lb_more = lb_lo_n < lb_hi_n;
  assign sts.ub_more = ub_lo_n < ub_hi_n;
  assign sts.hit     = (rdata_r == target_r);

  always_comb begin
    rd_addr = '0;
    unique case (cmd.op)
      CMD_START:    rd_addr = (count_r - 1'b1) >> 1;
      CMD_LB_STEP:  rd_addr = sts.lb_more ? midpoint(lb_lo_n, lb_hi_n) : lb_lo_n;
      CMD_LB_CHECK: rd_addr = midpoint(lo_r, count_r);
      CMD_UB_STEP:  rd_addr = midpoint(ub_lo_n, ub_hi_n);
      default:      rd_addr = '0;
    endcase
  end

  // Store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LOAD && wr_ok) begin
      mem[wr_idx[IDX_W-1:0]] <= in_value;
    end
    rdata_r <= mem[rd_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.op == CMD_LOAD && wr_ok) begin
      count_r <= wr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_START: begin
        target_r <= in_value;
        lo_r     <= '0;
        hi_r     <= count_r - 1'b1;
        mid_r    <= rd_addr;
        found_r  <= 1'b0;
      end
      CMD_LB_STEP: begin
        lo_r  <= lb_lo_n;
        hi_r  <= lb_hi_n;
        mid_r <= rd_addr;
      end
      CMD_LB_CHECK: begin
        if (sts.hit) begin
          first_r <= lo_r;
          hi_r    <= count_r;
          mid_r   <= rd_addr;
          found_r <= 1'b1;
        end
      end
      CMD_UB_STEP: begin
        lo_r  <= ub_lo_n;
        hi_r  <= ub_hi_n;
        mid_r <= rd_addr;
      end
      CMD_OUT_LOAD: begin
        out_found_r <= found_r;
        out_first_r <= found_r ? signed'(OUT_IDX_W'(first_r)) : '1;
        out_last_r  <= found_r ? signed'(OUT_IDX_W'(lo_r - 1'b1)) : '1;
      end
      default: begin
      end
    endcase
  end

  assign out_found       = out_found_r;
  assign out_first_index = out_first_r;
  assign out_last_index  = out_last_r;

  `SRS_ASSERT_NOW(a_step_bounds, clk, rst_n, cmd.op == CMD_LB_STEP || cmd.op == CMD_UB_STEP, lo_r < hi_r && hi_r <= count_r, "search bounds out of order")
  `SRS_ASSERT_NOW(a_mid_inside, clk, rst_n, cmd.op == CMD_LB_STEP || cmd.op == CMD_UB_STEP, mid_r >= lo_r && mid_r < hi_r, "probe outside bounds")
  `SRS_ASSERT_NEXT(a_restart_count, clk, rst_n, cmd.op == CMD_LOAD && in_restart, count_r == CNT_W'(1), "restart did not leave one word")

endmodule

`default_nettype wire

// ----- sv/sorted_range_search_unit.sv -----
// Top level of the sorted range search unit: channel glue around controller and datapath.
// Depends on srs_pkg, srs_if, srs_ctrl and srs_datapath.
//
//   Channel  Dir  Carries                                  Transaction
//   in_ch    in   mode, value, restart                     load one word or query a target
//   out_ch   out  found, first_index, last_index           one per query, none per load
//
// A load writes one word. A query on a non-empty store runs a lower-bound binary search,
// checks the word it ends on and, on a hit, runs an upper-bound search; each search makes
// about log2 of the word count probes, one at a time through the store's single read port.
// Reset (rst_n, synchronous) empties the store; the store itself is not cleared.
// A finished result waits in the output register; a new item is taken meanwhile, and a
// query finishing while that register is still full holds until it is taken.
`default_nettype none

module sorted_range_search_unit import srs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  srs_in_if.sink    in_ch,
  srs_out_if.source out_ch
);

  srs_cmd_t cmd;
  srs_sts_t sts;

  // Sequencer: owns the handshakes and the search order.
  srs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Store, bounds and result register.
  srs_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_value        (in_ch.value),
    .in_restart      (in_ch.restart),
    .sts             (sts),
    .out_found       (out_ch.found),
    .out_first_index (out_ch.first_index),
    .out_last_index  (out_ch.last_index)
  );

endmodule

`default_nettype wire
